@@ rtl/core/kclc_pkg.sv @@
// ----------------------------------------------------------------------------
// kclc_pkg: keypad code lock controller package
// Item and register types, operation, key, door, verdict and sound codes,
// and the code digit helper shared by the lock core and the top level.
// ----------------------------------------------------------------------------
package kclc_pkg;

   // Widths fixed by the item and register fields
   localparam int TIMER_W     = 24;
   localparam int CODE_W      = 24;
   localparam int CODE_DIGITS = 6;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam int MAX_CODE_DIGITS_DEFAULT = 6;

   localparam logic [TIMER_W-1:0] TIMER_MAX        = {TIMER_W{1'b1}};
   localparam logic [TIMER_W-1:0] KEY_DROP_RESET   = 24'd5000;
   localparam logic [TIMER_W-1:0] DOOR_CLOSE_RESET = 24'd10000;

   // Operations
   localparam logic [2:0] OP_KEY          = 3'd0;
   localparam logic [2:0] OP_TICK         = 3'd1;
   localparam logic [2:0] OP_SOUND_DONE   = 3'd2;
   localparam logic [2:0] OP_REMOTE_OPEN  = 3'd3;
   localparam logic [2:0] OP_REMOTE_CLOSE = 3'd4;

   // Keys
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_CLEAR     = 4'd10;
   localparam logic [3:0] KEY_ENTER     = 4'd11;

   // Door states
   localparam logic [1:0] DOOR_CLOSED  = 2'd0;
   localparam logic [1:0] DOOR_OPENED  = 2'd1;
   localparam logic [1:0] DOOR_OPENING = 2'd2;
   localparam logic [1:0] DOOR_CLOSING = 2'd3;

   // Pending verdicts
   localparam logic [1:0] VERDICT_NONE  = 2'd0;
   localparam logic [1:0] VERDICT_ERROR = 2'd1;
   localparam logic [1:0] VERDICT_OPEN  = 2'd2;

   // Sound requests
   localparam logic [2:0] SND_NONE  = 3'd0;
   localparam logic [2:0] SND_BEEP  = 3'd1;
   localparam logic [2:0] SND_DROP  = 3'd2;
   localparam logic [2:0] SND_CRASH = 3'd3;
   localparam logic [2:0] SND_ERROR = 3'd4;
   localparam logic [2:0] SND_OPEN  = 3'd5;
   localparam logic [2:0] SND_CLOSE = 3'd6;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_CODE_A       = 3'd0;
   localparam logic [2:0] REG_CODE_LEN_A   = 3'd1;
   localparam logic [2:0] REG_CODE_B       = 3'd2;
   localparam logic [2:0] REG_CODE_LEN_B   = 3'd3;
   localparam logic [2:0] REG_KEY_DROP     = 3'd4;
   localparam logic [2:0] REG_DOOR_CLOSE   = 3'd5;

   typedef struct packed {
      logic [2:0] operation;
      logic       keypad_side;
      logic [3:0] key_code;
      logic       sound_playing;
   } req_item_type;

   typedef struct packed {
      logic [2:0] sound_request;
      logic [1:0] door_status;
      logic       lasers_on;
   } rsp_item_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code_side_a;
      logic signed [3:0]  code_length_a;
      logic [CODE_W-1:0]  code_side_b;
      logic signed [3:0]  code_length_b;
      logic [TIMER_W-1:0] key_drop_ticks;
      logic [TIMER_W-1:0] door_close_ticks;
   } cfg_type;

   // Digit pos of a code, first digit in the top nibble; past the sixth reads zero
   function automatic logic [3:0] code_digit(input logic [CODE_W-1:0] code, input int pos);
      logic [CODE_W-1:0] shifted;
      shifted = '0;
      if (pos < CODE_DIGITS) begin
         shifted = code >> (4 * (CODE_DIGITS - 1 - pos));
      end
      return shifted[3:0];
   endfunction

endpackage

@@ rtl/core/kclc_core.sv @@
// ----------------------------------------------------------------------------
// kclc_core: lock state and per-item next-state logic
// Holds door state, entry buffer, verdict, timers and laser enable, and
// works out one item's result and state update combinationally.
// ----------------------------------------------------------------------------
module kclc_core #(
   parameter int MAX_CODE_DIGITS = kclc_pkg::MAX_CODE_DIGITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  kclc_pkg::req_item_type item,
   input  kclc_pkg::cfg_type      cfg,
   output kclc_pkg::rsp_item_type result
);

   localparam int CNT_W = $clog2(MAX_CODE_DIGITS + 1);
   localparam int IDX_W = (MAX_CODE_DIGITS > 1) ? $clog2(MAX_CODE_DIGITS) : 1;
   localparam int LEN_W = (CNT_W > 3) ? CNT_W : 3;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_DIGITS);

   logic [1:0]                   door_state_ff, door_state_in;
   logic [3:0]                   digits_ff [MAX_CODE_DIGITS];
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [1:0]                   verdict_ff, verdict_in;
   logic [kclc_pkg::TIMER_W-1:0] key_timer_ff, key_timer_in;
   logic [kclc_pkg::TIMER_W-1:0] door_timer_ff, door_timer_in;
   logic                         laser_ff, laser_in;

   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic [2:0]                   snd;

   logic [kclc_pkg::CODE_W-1:0]  side_code;
   logic signed [3:0]            side_len_raw;
   logic [LEN_W-1:0]             len_raw;
   logic [LEN_W-1:0]             len;
   logic [LEN_W-1:0]             count_ext;
   logic [MAX_CODE_DIGITS-1:0]   digit_ok;
   logic                         match;
   logic [kclc_pkg::TIMER_W-1:0] key_timer_inc;
   logic [kclc_pkg::TIMER_W-1:0] door_timer_inc;
   logic [1:0]                   door_after_verdict;

   // Select the pressed side's code and cap its length
   assign side_code    = item.keypad_side ? cfg.code_side_b : cfg.code_side_a;
   assign side_len_raw = item.keypad_side ? cfg.code_length_b : cfg.code_length_a;
   assign len_raw      = LEN_W'(side_len_raw[2:0]);
   assign len          = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
   assign count_ext    = LEN_W'(count_ff);

   // Compare each stored digit against the code, only below the length
   for (genvar i = 0; i < MAX_CODE_DIGITS; i++) begin : g_cmp
      assign digit_ok[i] = (LEN_W'(i) >= len) ||
                           (digits_ff[i] == kclc_pkg::code_digit(side_code, i));
   end
   assign match = (count_ext == len) && (&digit_ok);

   // Saturating timer increments
   assign key_timer_inc  = (key_timer_ff != kclc_pkg::TIMER_MAX) ?
                           key_timer_ff + 1'b1 : key_timer_ff;
   assign door_timer_inc = (door_timer_ff != kclc_pkg::TIMER_MAX) ?
                           door_timer_ff + 1'b1 : door_timer_ff;

   // Next state and sound for one item
   always_comb begin
      door_state_in      = door_state_ff;
      count_in           = count_ff;
      verdict_in         = verdict_ff;
      key_timer_in       = key_timer_ff;
      door_timer_in      = door_timer_ff;
      laser_in           = laser_ff;
      wr_en              = 1'b0;
      wr_idx             = count_ff[IDX_W-1:0];
      snd                = kclc_pkg::SND_NONE;
      door_after_verdict = door_state_ff;

      case (item.operation)
         kclc_pkg::OP_KEY: begin
            if (verdict_ff != kclc_pkg::VERDICT_NONE) begin
               snd = kclc_pkg::SND_NONE;
            end else if (side_len_raw[3]) begin
               snd = item.sound_playing ? kclc_pkg::SND_NONE : kclc_pkg::SND_CRASH;
            end else if (item.key_code <= kclc_pkg::KEY_DIGIT_MAX) begin
               snd = kclc_pkg::SND_BEEP;
               if (len != '0) begin
                  if (count_ext < len) begin
                     wr_en        = 1'b1;
                     count_in     = count_ff + 1'b1;
                     key_timer_in = '0;
                  end else begin
                     verdict_in = kclc_pkg::VERDICT_ERROR;
                  end
               end
            end else if (item.key_code == kclc_pkg::KEY_CLEAR) begin
               key_timer_in = cfg.key_drop_ticks;
            end else if (item.key_code == kclc_pkg::KEY_ENTER) begin
               if (door_state_ff == kclc_pkg::DOOR_OPENED) begin
                  door_state_in = kclc_pkg::DOOR_CLOSING;
                  snd           = kclc_pkg::SND_CLOSE;
               end else if (door_state_ff == kclc_pkg::DOOR_CLOSED) begin
                  if (len == '0 || match) begin
                     verdict_in = kclc_pkg::VERDICT_OPEN;
                  end else begin
                     verdict_in = kclc_pkg::VERDICT_ERROR;
                  end
               end
            end
         end
         kclc_pkg::OP_TICK: begin
            key_timer_in  = key_timer_inc;
            door_timer_in = door_timer_inc;
            // Act on the pending verdict or drop a stale entry
            if (!item.sound_playing) begin
               if (verdict_ff == kclc_pkg::VERDICT_NONE) begin
                  if (count_ff != '0 && key_timer_inc >= cfg.key_drop_ticks) begin
                     key_timer_in = '0;
                     count_in     = '0;
                     snd          = kclc_pkg::SND_DROP;
                  end
               end else if (verdict_ff == kclc_pkg::VERDICT_ERROR) begin
                  count_in   = '0;
                  verdict_in = kclc_pkg::VERDICT_NONE;
                  snd        = kclc_pkg::SND_ERROR;
               end else begin
                  count_in           = '0;
                  verdict_in         = kclc_pkg::VERDICT_NONE;
                  door_after_verdict = kclc_pkg::DOOR_OPENING;
                  door_state_in      = kclc_pkg::DOOR_OPENING;
                  door_timer_in      = '0;
                  snd                = kclc_pkg::SND_OPEN;
               end
            end
            // Auto close an opened door; its sound wins
            if (door_after_verdict == kclc_pkg::DOOR_OPENED &&
                door_timer_inc >= cfg.door_close_ticks) begin
               door_timer_in = '0;
               door_state_in = kclc_pkg::DOOR_CLOSING;
               snd           = kclc_pkg::SND_CLOSE;
            end
         end
         kclc_pkg::OP_SOUND_DONE: begin
            if (door_state_ff == kclc_pkg::DOOR_OPENING) begin
               door_state_in = kclc_pkg::DOOR_OPENED;
               laser_in      = 1'b0;
            end else if (door_state_ff == kclc_pkg::DOOR_CLOSING) begin
               door_state_in = kclc_pkg::DOOR_CLOSED;
               laser_in      = 1'b1;
            end
         end
         kclc_pkg::OP_REMOTE_OPEN: begin
            if (door_state_ff == kclc_pkg::DOOR_CLOSED) begin
               door_state_in = kclc_pkg::DOOR_OPENING;
               door_timer_in = '0;
               snd           = kclc_pkg::SND_OPEN;
            end
         end
         kclc_pkg::OP_REMOTE_CLOSE: begin
            if (door_state_ff == kclc_pkg::DOOR_OPENED) begin
               door_state_in = kclc_pkg::DOOR_CLOSING;
               snd           = kclc_pkg::SND_CLOSE;
            end
         end
         default: begin
            snd = kclc_pkg::SND_NONE;
         end
      endcase
   end

   assign result.sound_request = snd;
   assign result.door_status   = door_state_in;
   assign result.lasers_on     = laser_in;

   // Advance control state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         door_state_ff <= kclc_pkg::DOOR_CLOSED;
         count_ff      <= '0;
         verdict_ff    <= kclc_pkg::VERDICT_NONE;
         key_timer_ff  <= '0;
         door_timer_ff <= '0;
         laser_ff      <= 1'b1;
      end else if (step_en) begin
         door_state_ff <= door_state_in;
         count_ff      <= count_in;
         verdict_ff    <= verdict_in;
         key_timer_ff  <= key_timer_in;
         door_timer_ff <= door_timer_in;
         laser_ff      <= laser_in;
      end
   end

   // Store an entered digit
   always_ff @(posedge clock) begin
      if (step_en && wr_en) begin
         digits_ff[wr_idx] <= item.key_code;
      end
   end

endmodule

@@ rtl/core/keypad_code_lock_controller_top.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_top: two-keypad code lock controller
// Input item register, lock core, result register and APB register file.
// ----------------------------------------------------------------------------
// A taken item waits in the input register; its result is captured in the result register once that is free.
// Throughput: one item per cycle while results drain; the lock core updates all state in one pass.
// While a result waits, the input register takes one more item, then holds.
// Reset (synchronous, active high): door closed, lasers on, no entry, no
// verdict, timers zero, codes cleared, drop and close delays at defaults.
module keypad_code_lock_controller_top #(
   parameter int MAX_CODE_DIGITS = kclc_pkg::MAX_CODE_DIGITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  kclc_pkg::req_item_type             req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output kclc_pkg::rsp_item_type             rsp_item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [kclc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [kclc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [kclc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   logic                   in_valid_ff;
   kclc_pkg::req_item_type in_item_ff;
   logic                   rsp_valid_ff;
   kclc_pkg::rsp_item_type rsp_item_ff;
   kclc_pkg::rsp_item_type step_result;
   kclc_pkg::cfg_type      cfg_ff;
   logic                   out_free;
   logic                   step_en;
   logic                   csr_write;
   logic [2:0]             csr_index;

   // Handshake: the result register frees as it drains
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
   end

   kclc_core #(
      .MAX_CODE_DIGITS(MAX_CODE_DIGITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step_en(step_en),
      .item   (in_item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // Capture the result item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_item_ff <= step_result;
      end
   end

   // Register file writes
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_side_a      <= '0;
         cfg_ff.code_length_a    <= '0;
         cfg_ff.code_side_b      <= '0;
         cfg_ff.code_length_b    <= '0;
         cfg_ff.key_drop_ticks   <= kclc_pkg::KEY_DROP_RESET;
         cfg_ff.door_close_ticks <= kclc_pkg::DOOR_CLOSE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            kclc_pkg::REG_CODE_A:     cfg_ff.code_side_a      <= pwdata[23:0];
            kclc_pkg::REG_CODE_LEN_A: cfg_ff.code_length_a    <= pwdata[3:0];
            kclc_pkg::REG_CODE_B:     cfg_ff.code_side_b      <= pwdata[23:0];
            kclc_pkg::REG_CODE_LEN_B: cfg_ff.code_length_b    <= pwdata[3:0];
            kclc_pkg::REG_KEY_DROP:   cfg_ff.key_drop_ticks   <= pwdata[23:0];
            kclc_pkg::REG_DOOR_CLOSE: cfg_ff.door_close_ticks <= pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // Register file reads
   always_comb begin
      case (csr_index)
         kclc_pkg::REG_CODE_A:     prdata = 32'(cfg_ff.code_side_a);
         kclc_pkg::REG_CODE_LEN_A: prdata = {28'd0, cfg_ff.code_length_a};
         kclc_pkg::REG_CODE_B:     prdata = 32'(cfg_ff.code_side_b);
         kclc_pkg::REG_CODE_LEN_B: prdata = {28'd0, cfg_ff.code_length_b};
         kclc_pkg::REG_KEY_DROP:   prdata = 32'(cfg_ff.key_drop_ticks);
         kclc_pkg::REG_DOOR_CLOSE: prdata = 32'(cfg_ff.door_close_ticks);
         default:                  prdata = '0;
      endcase
   end

endmodule

@@ tb/sv/keypad_code_lock_controller_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_top_tb: self-checking bench for the code lock
// Drives key, tick, sound-done and remote items through the valid/ready
// channel and writes the code and delay registers over APB between phases.
// A behavioral lock model predicts results the table does not type. A short
// directed table runs first. Randomized code-entry sessions and noise follow,
// under several register settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_top_tb;
   import kclc_pkg::*;

   localparam int         STALL_LIMIT = 4000;
   localparam int         DIGIT_CAP   = MAX_CODE_DIGITS_DEFAULT;
   localparam logic [2:0] OP_UNKNOWN  = 3'd7;
   localparam logic [3:0] KEY_UNKNOWN = 4'd15;
   localparam logic       SIDE_A      = 1'b0;
   localparam logic       SIDE_B      = 1'b1;

   typedef struct packed {
      logic          is_cfg;
      logic [2:0]    reg_idx;
      logic [31:0]   reg_val;
      req_item_type  item;
      logic          typed;
      rsp_item_type  res;
   } plan_row_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_item;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Lock model: registers
   logic [CODE_W-1:0]  code_a      = '0;
   logic [CODE_W-1:0]  code_b      = '0;
   logic [3:0]         len_a       = '0;
   logic [3:0]         len_b       = '0;
   logic [TIMER_W-1:0] drop_delay  = KEY_DROP_RESET;
   logic [TIMER_W-1:0] close_delay = DOOR_CLOSE_RESET;

   // Lock model: state
   logic [1:0]         door_st     = DOOR_CLOSED;
   logic [3:0]         entry_digits [DIGIT_CAP];
   int                 digit_cnt   = 0;
   logic [1:0]         verdict     = VERDICT_NONE;
   logic [TIMER_W-1:0] key_ticks   = '0;
   logic [TIMER_W-1:0] door_ticks  = '0;
   logic               lasers      = 1'b1;

   rsp_item_type  lock_results_due [$];
   plan_row_type  plan_rows [$];
   int            items_sent     = 0;
   int            mismatch_count = 0;
   int            stall_cycles   = 0;
   logic          idle_mode      = 1'b1;

   keypad_code_lock_controller_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the lock model by one item and return the result it causes
   function automatic rsp_item_type next_lock_result(input req_item_type it);
      rsp_item_type      res;
      logic [2:0]        snd;
      logic [CODE_W-1:0] code;
      logic [3:0]        lraw;
      int                len;
      int                i;
      logic              same;
      snd = SND_NONE;
      case (it.operation)
         OP_KEY: begin
            code = it.keypad_side ? code_b : code_a;
            lraw = it.keypad_side ? len_b : len_a;
            len  = (int'(lraw[2:0]) > DIGIT_CAP) ? DIGIT_CAP : int'(lraw[2:0]);
            if (verdict != VERDICT_NONE) begin
               // keys are dead while a verdict waits for its tick
            end else if (lraw[3]) begin
               if (!it.sound_playing) snd = SND_CRASH;
            end else if (it.key_code <= KEY_DIGIT_MAX) begin
               if (len > 0) begin
                  if (digit_cnt < len) begin
                     entry_digits[digit_cnt] = it.key_code;
                     digit_cnt++;
                     key_ticks = '0;
                  end else begin
                     verdict = VERDICT_ERROR;
                  end
               end
               snd = SND_BEEP;
            end else if (it.key_code == KEY_CLEAR) begin
               key_ticks = drop_delay;
            end else if (it.key_code == KEY_ENTER) begin
               if (door_st == DOOR_OPENED) begin
                  door_st = DOOR_CLOSING;
                  snd     = SND_CLOSE;
               end else if (door_st == DOOR_CLOSED) begin
                  if (len == 0) begin
                     verdict = VERDICT_OPEN;
                  end else begin
                     // compare only the first len digits, counts must agree
                     same = (digit_cnt == len);
                     for (i = 0; i < len; i++) begin
                        if (same && entry_digits[i] != code[4*(CODE_DIGITS-1-i) +: 4])
                           same = 1'b0;
                     end
                     verdict = same ? VERDICT_OPEN : VERDICT_ERROR;
                  end
               end
            end
         end
         OP_TICK: begin
            if (key_ticks != TIMER_MAX) key_ticks = key_ticks + 1'b1;
            if (door_ticks != TIMER_MAX) door_ticks = door_ticks + 1'b1;
            if (!it.sound_playing) begin
               if (verdict == VERDICT_NONE) begin
                  if (digit_cnt != 0 && key_ticks >= drop_delay) begin
                     key_ticks = '0;
                     digit_cnt = 0;
                     snd       = SND_DROP;
                  end
               end else if (verdict == VERDICT_ERROR) begin
                  digit_cnt = 0;
                  verdict   = VERDICT_NONE;
                  snd       = SND_ERROR;
               end else begin
                  digit_cnt  = 0;
                  verdict    = VERDICT_NONE;
                  door_st    = DOOR_OPENING;
                  door_ticks = '0;
                  snd        = SND_OPEN;
               end
            end
            // auto close wins over a drop in the same tick
            if (door_st == DOOR_OPENED && door_ticks >= close_delay) begin
               door_ticks = '0;
               door_st    = DOOR_CLOSING;
               snd        = SND_CLOSE;
            end
         end
         OP_SOUND_DONE: begin
            if (door_st == DOOR_OPENING) begin
               door_st = DOOR_OPENED;
               lasers  = 1'b0;
            end else if (door_st == DOOR_CLOSING) begin
               door_st = DOOR_CLOSED;
               lasers  = 1'b1;
            end
         end
         OP_REMOTE_OPEN: begin
            if (door_st == DOOR_CLOSED) begin
               door_st    = DOOR_OPENING;
               door_ticks = '0;
               snd        = SND_OPEN;
            end
         end
         OP_REMOTE_CLOSE: begin
            if (door_st == DOOR_OPENED) begin
               door_st = DOOR_CLOSING;
               snd     = SND_CLOSE;
            end
         end
         default: begin
         end
      endcase
      res.sound_request = snd;
      res.door_status   = door_st;
      res.lasers_on     = lasers;
      return res;
   endfunction

   function automatic void plan_evt(input logic [2:0] op, input logic side,
                                    input logic [3:0] key, input logic playing);
      plan_row_type row;
      row                    = '0;
      row.item.operation     = op;
      row.item.keypad_side   = side;
      row.item.key_code      = key;
      row.item.sound_playing = playing;
      plan_rows.push_back(row);
   endfunction

   function automatic void plan_chk(input logic [2:0] op, input logic side,
                                    input logic [3:0] key, input logic playing,
                                    input logic [2:0] snd, input logic [1:0] door,
                                    input logic lasers_on);
      plan_row_type row;
      row                    = '0;
      row.item.operation     = op;
      row.item.keypad_side   = side;
      row.item.key_code      = key;
      row.item.sound_playing = playing;
      row.typed              = 1'b1;
      row.res.sound_request  = snd;
      row.res.door_status    = door;
      row.res.lasers_on      = lasers_on;
      plan_rows.push_back(row);
   endfunction

   function automatic void plan_cfg(input logic [2:0] idx, input logic [31:0] val);
      plan_row_type row;
      row         = '0;
      row.is_cfg  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      plan_rows.push_back(row);
   endfunction

   function automatic logic busy_draw();
      return ($urandom_range(0, 4) == 0);
   endfunction

   function automatic logic [CODE_W-1:0] bcd_code();
      logic [CODE_W-1:0] code;
      int                i;
      for (i = 0; i < CODE_DIGITS; i++) code[4*i +: 4] = 4'($urandom_range(0, 9));
      return code;
   endfunction

   function automatic logic [3:0] len_draw();
      return ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 6));
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Present one item, hold it until taken, then record its expected result
   task automatic send_item(input req_item_type it, input logic typed,
                            input rsp_item_type typed_res);
      int           gap;
      rsp_item_type res;
      gap = idle_mode ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = next_lock_result(it);
      lock_results_due.push_back(typed ? typed_res : res);
      items_sent++;
   endtask

   task automatic push_event(input logic [2:0] op, input logic side,
                             input logic [3:0] key, input logic playing);
      req_item_type it;
      it.operation     = op;
      it.keypad_side   = side;
      it.key_code      = key;
      it.sound_playing = playing;
      send_item(it, 1'b0, '0);
   endtask

   // Write one register once every result is in; psel stays up for the next write
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      req_valid <= 1'b0;
      while (lock_results_due.size() != 0) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_CODE_A:     code_a      = val[CODE_W-1:0];
         REG_CODE_LEN_A: len_a       = val[3:0];
         REG_CODE_B:     code_b      = val[CODE_W-1:0];
         REG_CODE_LEN_B: len_b       = val[3:0];
         REG_KEY_DROP:   drop_delay  = val[TIMER_W-1:0];
         REG_DOOR_CLOSE: close_delay = val[TIMER_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic end_csr();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Pick the register setting of a random phase; the first two are the extremes
   task automatic configure_lock(input int phase);
      logic [CODE_W-1:0]  ca, cb;
      logic [3:0]         la, lb;
      logic [TIMER_W-1:0] dt, ct;
      case (phase)
         0: begin
            ca = bcd_code();
            la = 4'd6;
            cb = bcd_code();
            lb = 4'd1;
            dt = '0;
            ct = '0;
         end
         1: begin
            ca = {CODE_W{1'b1}};
            la = 4'd7;
            cb = 24'h999999;
            lb = 4'h8;
            dt = TIMER_MAX;
            ct = TIMER_MAX;
         end
         default: begin
            ca = ($urandom_range(0, 3) == 0) ? CODE_W'($urandom) : bcd_code();
            la = len_draw();
            cb = ($urandom_range(0, 3) == 0) ? CODE_W'($urandom) : bcd_code();
            lb = len_draw();
            dt = ($urandom_range(0, 7) == 0) ? TIMER_W'($urandom)
                                             : TIMER_W'($urandom_range(0, 8));
            ct = TIMER_W'($urandom_range(0, 12));
         end
      endcase
      write_reg(REG_CODE_A, {8'd0, ca});
      write_reg(REG_CODE_LEN_A, {{28{la[3]}}, la});
      write_reg(REG_CODE_B, {8'd0, cb});
      write_reg(REG_CODE_LEN_B, {{28{lb[3]}}, lb});
      write_reg(REG_KEY_DROP, {8'd0, dt});
      write_reg(REG_DOOR_CLOSE, {8'd0, ct});
      end_csr();
   endtask

   // One session: mostly a code entry ending in the enter key, else a remote
   // request or noise, then a tail of ticks, sound-done and door events
   task automatic run_session();
      int                kind, len, n, i;
      logic              side;
      logic [CODE_W-1:0] code;
      logic [3:0]        lraw, dg;
      idle_mode = ($urandom_range(0, 3) != 0);
      kind      = $urandom_range(0, 9);
      side      = 1'($urandom_range(0, 1));
      if (kind <= 5) begin
         code = side ? code_b : code_a;
         lraw = side ? len_b : len_a;
         len  = lraw[3] ? 2 : ((int'(lraw[2:0]) > DIGIT_CAP) ? DIGIT_CAP : int'(lraw[2:0]));
         n    = len;
         case ($urandom_range(0, 7))
            0: n = len + 1;
            1: n = $urandom_range(0, len);
            default: begin
            end
         endcase
         for (i = 0; i < n; i++) begin
            dg = (i < CODE_DIGITS) ? code[4*(CODE_DIGITS-1-i) +: 4] : 4'($urandom_range(0, 9));
            if ($urandom_range(0, 5) == 0 || dg > KEY_DIGIT_MAX) dg = 4'($urandom_range(0, 9));
            push_event(OP_KEY, side, dg, busy_draw());
         end
         if ($urandom_range(0, 7) == 0) push_event(OP_KEY, side, KEY_CLEAR, busy_draw());
         push_event(OP_KEY, side, KEY_ENTER, busy_draw());
      end else if (kind == 6) begin
         push_event($urandom_range(0, 1) ? OP_REMOTE_OPEN : OP_REMOTE_CLOSE, side,
                    4'($urandom), busy_draw());
      end else begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++)
            push_event(3'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      end
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0, 1, 2, 3: push_event(OP_TICK, side, 4'($urandom), busy_draw());
            4, 5:       push_event(OP_SOUND_DONE, side, 4'($urandom), busy_draw());
            6:          push_event(OP_KEY, 1'($urandom), KEY_ENTER, busy_draw());
            default:    push_event($urandom_range(0, 1) ? OP_REMOTE_OPEN : OP_REMOTE_CLOSE,
                                   side, 4'($urandom), busy_draw());
         endcase
      end
   endtask

   // Result side: stall at random, then compare each taken item with the oldest due
   initial begin : result_side
      int           stall;
      rsp_item_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_mode ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
         if (lock_results_due.size() == 0) begin
            report_mismatch($sformatf("result %0h with none due", rsp_item));
         end else begin
            want = lock_results_due.pop_front();
            if (rsp_item.sound_request !== want.sound_request)
               report_mismatch($sformatf("sound_request got %0d want %0d",
                                         rsp_item.sound_request, want.sound_request));
            if (rsp_item.door_status !== want.door_status)
               report_mismatch($sformatf("door_status got %0d want %0d",
                                         rsp_item.door_status, want.door_status));
            if (rsp_item.lasers_on !== want.lasers_on)
               report_mismatch($sformatf("lasers_on got %0d want %0d",
                                         rsp_item.lasers_on, want.lasers_on));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[keypad_code_lock_controller_top] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int   r, phase, target;
      logic csr_open;
      csr_open = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset setting: no codes, so digits only beep and the enter key opens
      plan_chk(OP_SOUND_DONE, SIDE_A, 4'd0, 1'b0, SND_NONE, DOOR_CLOSED, 1'b1);
      plan_chk(OP_UNKNOWN, SIDE_B, KEY_UNKNOWN, 1'b1, SND_NONE, DOOR_CLOSED, 1'b1);
      plan_chk(OP_KEY, SIDE_A, 4'd9, 1'b0, SND_BEEP, DOOR_CLOSED, 1'b1);
      plan_chk(OP_KEY, SIDE_A, KEY_ENTER, 1'b0, SND_NONE, DOOR_CLOSED, 1'b1);
      plan_chk(OP_KEY, SIDE_A, 4'd0, 1'b0, SND_NONE, DOOR_CLOSED, 1'b1);
      plan_chk(OP_TICK, SIDE_A, 4'd0, 1'b1, SND_NONE, DOOR_CLOSED, 1'b1);
      plan_chk(OP_TICK, SIDE_A, 4'd0, 1'b0, SND_OPEN, DOOR_OPENING, 1'b1);
      plan_evt(OP_KEY, SIDE_B, KEY_ENTER, 1'b0);
      plan_chk(OP_SOUND_DONE, SIDE_A, 4'd0, 1'b0, SND_NONE, DOOR_OPENED, 1'b0);
      plan_chk(OP_KEY, SIDE_B, KEY_ENTER, 1'b0, SND_CLOSE, DOOR_CLOSING, 1'b0);
      plan_chk(OP_SOUND_DONE, SIDE_A, 4'd0, 1'b0, SND_NONE, DOOR_CLOSED, 1'b1);

      // Two-digit code on A, crashed B, zero delays
      plan_cfg(REG_CODE_A, 32'h0009_0000);
      plan_cfg(REG_CODE_LEN_A, 32'h0000_0002);
      plan_cfg(REG_CODE_B, 32'h00FF_FFFF);
      plan_cfg(REG_CODE_LEN_B, 32'hFFFF_FFFF);
      plan_cfg(REG_KEY_DROP, 32'h0000_0000);
      plan_cfg(REG_DOOR_CLOSE, 32'h0000_0000);
      plan_chk(OP_KEY, SIDE_B, 4'd3, 1'b0, SND_CRASH, DOOR_CLOSED, 1'b1);
      plan_chk(OP_KEY, SIDE_B, 4'd3, 1'b1, SND_NONE, DOOR_CLOSED, 1'b1);
      plan_evt(OP_KEY, SIDE_A, 4'd0, 1'b0);
      plan_evt(OP_KEY, SIDE_A, 4'd9, 1'b0);
      plan_chk(OP_KEY, SIDE_A, 4'd5, 1'b0, SND_BEEP, DOOR_CLOSED, 1'b1);
      plan_chk(OP_TICK, SIDE_A, 4'd0, 1'b0, SND_ERROR, DOOR_CLOSED, 1'b1);
      plan_evt(OP_KEY, SIDE_A, 4'd0, 1'b0);
      plan_evt(OP_KEY, SIDE_A, 4'd9, 1'b0);
      plan_evt(OP_KEY, SIDE_A, KEY_ENTER, 1'b0);
      plan_evt(OP_TICK, SIDE_A, 4'd0, 1'b0);
      plan_evt(OP_SOUND_DONE, SIDE_A, 4'd0, 1'b0);
      plan_evt(OP_KEY, SIDE_A, 4'd4, 1'b0);
      plan_chk(OP_TICK, SIDE_A, 4'd0, 1'b0, SND_CLOSE, DOOR_CLOSING, 1'b0);
      plan_evt(OP_SOUND_DONE, SIDE_A, 4'd0, 1'b0);

      // Code nibble above nine on B, length cap on A, saturating drop delay
      plan_cfg(REG_CODE_A, 32'h0000_0000);
      plan_cfg(REG_CODE_LEN_A, 32'h0000_0007);
      plan_cfg(REG_CODE_B, 32'h00A0_0000);
      plan_cfg(REG_CODE_LEN_B, 32'h0000_0001);
      plan_cfg(REG_KEY_DROP, 32'h00FF_FFFF);
      plan_evt(OP_KEY, SIDE_B, 4'd0, 1'b0);
      plan_evt(OP_KEY, SIDE_B, KEY_ENTER, 1'b0);
      plan_chk(OP_TICK, SIDE_A, 4'd0, 1'b0, SND_ERROR, DOOR_CLOSED, 1'b1);
      plan_evt(OP_KEY, SIDE_A, 4'd3, 1'b0);
      plan_evt(OP_KEY, SIDE_A, KEY_CLEAR, 1'b0);
      plan_chk(OP_TICK, SIDE_A, 4'd0, 1'b0, SND_DROP, DOOR_CLOSED, 1'b1);

      // Walk the directed table
      for (r = 0; r < plan_rows.size(); r++) begin
         if (plan_rows[r].is_cfg) begin
            write_reg(plan_rows[r].reg_idx, plan_rows[r].reg_val);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               end_csr();
               csr_open = 1'b0;
            end
            send_item(plan_rows[r].item, plan_rows[r].typed, plan_rows[r].res);
         end
      end

      // Random phases, each under a fresh register setting
      for (phase = 0; phase < 6; phase++) begin
         configure_lock(phase);
         target = items_sent + 100;
         while (items_sent < target) run_session();
      end

      // Drain and settle
      req_valid <= 1'b0;
      while (lock_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[keypad_code_lock_controller_top] OK");
      else
         $display("[keypad_code_lock_controller_top] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/kclc_pkg.sv
rtl/core/kclc_core.sv
rtl/core/keypad_code_lock_controller_top.sv
tb/sv/keypad_code_lock_controller_top_tb.sv
